// ===== sv/rmq_pkg.sv =====
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int IN_W  = 16;
  localparam int DIF_W = IN_W + 1;
  localparam int N_IN  = 10;
  localparam int N_Q   = 4;

  // which component comes from the root; the others come from the three divider lanes
  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_Z,
    SEL_TRACE
  } sel_t;

  // side data that rides along the square root cells
  typedef struct packed {
    logic [2:0][DIF_W-1:0] dif;
    sel_t                  sel;
    logic                  bad;
  } side_t;

  // side data that rides along the divider cells
  typedef struct packed {
    logic [2:0] neg;
    sel_t       sel;
    logic       bad;
  } dside_t;

endpackage

// ===== sv/rmq_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One root bit per cell: brings down two radicand bits, tries (root << 2) | 1.
module rmq_sqrt_cell import rmq_pkg::*; #(
  parameter int RTW = 17,
  parameter int SW  = 34
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           i_vld,
  input  logic [RTW-1:0] i_root,
  input  logic [RTW+2:0] i_rem,
  input  logic [SW-1:0]  i_val,
  input  side_t          i_side,
  output logic           o_vld,
  output logic [RTW-1:0] o_root,
  output logic [RTW+2:0] o_rem,
  output logic [SW-1:0]  o_val,
  output side_t          o_side
);

  logic [RTW+2:0] rem_sh;
  logic [RTW+2:0] trial;
  logic           ge;
  logic           vld_r;
  logic [RTW-1:0] root_r, root_nxt;
  logic [RTW+2:0] rem_r, rem_nxt;
  logic [SW-1:0]  val_r;
  side_t          side_r;

  always_comb begin
    rem_sh   = {i_rem[RTW:0], i_val[SW-1:SW-2]};
    trial    = {1'b0, i_root, 2'b01};
    ge       = (rem_sh >= trial);
    root_nxt = {i_root[RTW-2:0], ge};
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= i_vld;
    end
    if (en) begin
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
      val_r  <= {i_val[SW-3:0], 2'b00};
      side_r <= i_side;
    end
  end

  assign o_vld  = vld_r;
  assign o_root = root_r;
  assign o_rem  = rem_r;
  assign o_val  = val_r;
  assign o_side = side_r;

endmodule

// ===== sv/rmq_div_cell.sv =====
`timescale 1ns / 1ps
// One quotient bit per cell for three restoring divider lanes sharing one divisor.
module rmq_div_cell import rmq_pkg::*; #(
  parameter int NW = 31,
  parameter int DW = 18,
  parameter int PW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 i_vld,
  input  logic [2:0][NW-1:0]   i_num,
  input  logic [2:0][DW-1:0]   i_rem,
  input  logic [2:0][NW-1:0]   i_q,
  input  logic [DW-1:0]        i_d,
  input  logic [PW-1:0]        i_piv,
  input  dside_t               i_ds,
  output logic                 o_vld,
  output logic [2:0][NW-1:0]   o_num,
  output logic [2:0][DW-1:0]   o_rem,
  output logic [2:0][NW-1:0]   o_q,
  output logic [DW-1:0]        o_d,
  output logic [PW-1:0]        o_piv,
  output dside_t               o_ds
);

  logic [2:0][DW:0]   rem_sh;
  logic [2:0]         ge;
  logic [2:0][DW-1:0] rem_nxt;
  logic [2:0][NW-1:0] q_nxt;
  logic               vld_r;
  logic [2:0][NW-1:0] num_r;
  logic [2:0][DW-1:0] rem_r;
  logic [2:0][NW-1:0] q_r;
  logic [DW-1:0]      d_r;
  logic [PW-1:0]      piv_r;
  dside_t             ds_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_sh[l]  = {i_rem[l], i_num[l][NW-1]};
      ge[l]      = (rem_sh[l] >= {1'b0, i_d});
      rem_nxt[l] = ge[l] ? DW'(rem_sh[l] - {1'b0, i_d}) : rem_sh[l][DW-1:0];
      q_nxt[l]   = {i_q[l][NW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= i_vld;
    end
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        num_r[l] <= {i_num[l][NW-2:0], 1'b0};
      end
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      d_r   <= i_d;
      piv_r <= i_piv;
      ds_r  <= i_ds;
    end
  end

  assign o_vld = vld_r;
  assign o_num = num_r;
  assign o_rem = rem_r;
  assign o_q   = q_r;
  assign o_d   = d_r;
  assign o_piv = piv_r;
  assign o_ds  = ds_r;

endmodule

// ===== sv/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// Rotation matrix to quaternion (Shepperd), fixed point with FRAC_BITS fraction bits.
// Fully pipelined: one item per cycle while the result side accepts. The stages are 1 front
// stage, one square root cell per root bit (RTW = half of the rounded-up radicand width, 17 at
// FRAC_BITS=14), one divider cell per quotient bit (17 + FRAC_BITS) and the output register.
// The cell chains set the latency, not the rate. When the result side stalls, one more item
// is taken into a skid register before in_tready drops.
// A non-positive pivot radicand gives zeros with radicand_bad set.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, m33 (16 bits each, from bit 0 up)
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // qx, qy, qz, qw (16 bits each, from bit 0 up)
  output logic [63:0]  out_tdata,
  // radicand_bad
  output logic [0:0]   out_tuser
);

  localparam int RW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int TW  = RW + 1;
  localparam int SW0 = RW + FRAC_BITS;
  localparam int SW  = SW0 + (SW0 % 2);
  localparam int RTW = SW / 2;
  localparam int DW  = RTW + 1;
  localparam int NW  = DIF_W + FRAC_BITS;
  localparam int PW  = RTW - 1;
  localparam int CW  = ((NW > PW) ? NW : PW) + 16;
  localparam logic signed [TW-1:0] ONE = TW'(1) <<< FRAC_BITS;

  logic en;
  logic signed [IN_W-1:0] m [N_IN];

  always_comb begin
    for (int n = 0; n < N_IN; n++) begin
      m[n] = in_tdata[n*IN_W +: IN_W];
    end
  end

  // ---------------- front stage ----------------
  logic signed [TW-1:0] tr, rad, mii, mjj, mkk;
  logic                 use_tr;
  logic [1:0]           piv_i;
  logic signed [IN_W-1:0] p_ii;
  side_t                side_f;
  logic [RW-1:0]        rad_u;
  logic                 vld0_r;
  logic [SW-1:0]        val0_r;
  side_t                side0_r;

  function automatic logic [DIF_W-1:0] sadd(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
                                            input logic sub);
    logic [DIF_W-1:0] ea, eb;
    ea = {a[IN_W-1], a};
    eb = {b[IN_W-1], b};
    return sub ? (ea - eb) : (ea + eb);
  endfunction

  always_comb begin
    tr     = TW'(m[0]) + TW'(m[4]) + TW'(m[8]) + TW'(m[9]);
    use_tr = (tr >= ONE);
    piv_i  = (m[0] <= m[4]) ? 2'd1 : 2'd0;
    p_ii   = (piv_i == 2'd1) ? m[4] : m[0];
    if (m[8] > p_ii) piv_i = 2'd2;
    case (piv_i)
      2'd0: begin
        mii = TW'(m[0]); mjj = TW'(m[4]); mkk = TW'(m[8]);
        side_f.sel = SEL_X;
        side_f.dif[0] = sadd(m[3], m[1], 1'b0);
        side_f.dif[1] = sadd(m[6], m[2], 1'b0);
        side_f.dif[2] = sadd(m[5], m[7], 1'b1);
      end
      2'd1: begin
        mii = TW'(m[4]); mjj = TW'(m[8]); mkk = TW'(m[0]);
        side_f.sel = SEL_Y;
        side_f.dif[0] = sadd(m[7], m[5], 1'b0);
        side_f.dif[1] = sadd(m[1], m[3], 1'b0);
        side_f.dif[2] = sadd(m[6], m[2], 1'b1);
      end
      default: begin
        mii = TW'(m[8]); mjj = TW'(m[0]); mkk = TW'(m[4]);
        side_f.sel = SEL_Z;
        side_f.dif[0] = sadd(m[2], m[6], 1'b0);
        side_f.dif[1] = sadd(m[5], m[7], 1'b0);
        side_f.dif[2] = sadd(m[1], m[3], 1'b1);
      end
    endcase
    rad        = mii - mjj - mkk + ONE;
    side_f.bad = 1'b0;
    if (use_tr) begin
      rad = tr;
      side_f.sel = SEL_TRACE;
      side_f.dif[0] = sadd(m[5], m[7], 1'b1);
      side_f.dif[1] = sadd(m[6], m[2], 1'b1);
      side_f.dif[2] = sadd(m[1], m[3], 1'b1);
    end else if (rad <= 0) begin
      side_f.bad = 1'b1;
    end
    rad_u = side_f.bad ? RW'(1) : rad[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid;
    end
    if (en) begin
      val0_r  <= {{(SW-RW){1'b0}}, rad_u} << FRAC_BITS;
      side0_r <= side_f;
    end
  end

  // ---------------- square root chain ----------------
  logic           s_vld  [RTW+1];
  logic [RTW-1:0] s_root [RTW+1];
  logic [RTW+2:0] s_rem  [RTW+1];
  logic [SW-1:0]  s_val  [RTW+1];
  side_t          s_side [RTW+1];

  assign s_vld[0]  = vld0_r;
  assign s_root[0] = '0;
  assign s_rem[0]  = '0;
  assign s_val[0]  = val0_r;
  assign s_side[0] = side0_r;

  for (genvar s = 0; s < RTW; s++) begin : g_sqrt
    rmq_sqrt_cell #(.RTW(RTW), .SW(SW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .i_vld  (s_vld[s]),
      .i_root (s_root[s]),
      .i_rem  (s_rem[s]),
      .i_val  (s_val[s]),
      .i_side (s_side[s]),
      .o_vld  (s_vld[s+1]),
      .o_root (s_root[s+1]),
      .o_rem  (s_rem[s+1]),
      .o_val  (s_val[s+1]),
      .o_side (s_side[s+1])
    );
  end

  // ---------------- divider chain ----------------
  logic               d_vld [NW+1];
  logic [2:0][NW-1:0] d_num [NW+1];
  logic [2:0][DW-1:0] d_rem [NW+1];
  logic [2:0][NW-1:0] d_q   [NW+1];
  logic [DW-1:0]      d_d   [NW+1];
  logic [PW-1:0]      d_piv [NW+1];
  dside_t             d_ds  [NW+1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      d_num[0][l] = NW'(s_side[RTW].dif[l][DIF_W-1] ? (DIF_W'(0) - s_side[RTW].dif[l])
                                                     : s_side[RTW].dif[l]) << FRAC_BITS;
      d_ds[0].neg[l] = s_side[RTW].dif[l][DIF_W-1];
    end
    d_ds[0].sel = s_side[RTW].sel;
    d_ds[0].bad = s_side[RTW].bad;
  end

  assign d_vld[0] = s_vld[RTW];
  assign d_rem[0] = '0;
  assign d_q[0]   = '0;
  assign d_d[0]   = {s_root[RTW], 1'b0};
  assign d_piv[0] = s_root[RTW][RTW-1:1];

  for (genvar c = 0; c < NW; c++) begin : g_div
    rmq_div_cell #(.NW(NW), .DW(DW), .PW(PW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .i_vld (d_vld[c]),
      .i_num (d_num[c]),
      .i_rem (d_rem[c]),
      .i_q   (d_q[c]),
      .i_d   (d_d[c]),
      .i_piv (d_piv[c]),
      .i_ds  (d_ds[c]),
      .o_vld (d_vld[c+1]),
      .o_num (d_num[c+1]),
      .o_rem (d_rem[c+1]),
      .o_q   (d_q[c+1]),
      .o_d   (d_d[c+1]),
      .o_piv (d_piv[c+1]),
      .o_ds  (d_ds[c+1])
    );
  end

  // ---------------- saturate and place ----------------
  logic [2:0][IN_W-1:0] lane_s;
  logic [IN_W-1:0]      piv_s;
  logic [N_Q-1:0][IN_W-1:0] q_fin;
  logic [64:0]          res;
  dside_t               ds_e;

  always_comb begin
    ds_e = d_ds[NW];
    for (int l = 0; l < 3; l++) begin
      if (ds_e.neg[l]) begin
        lane_s[l] = (CW'(d_q[NW][l]) > CW'(32768)) ? 16'h8000
                                                  : IN_W'(NW'(0) - d_q[NW][l]);
      end else begin
        lane_s[l] = (CW'(d_q[NW][l]) > CW'(32767)) ? 16'h7FFF : d_q[NW][l][IN_W-1:0];
      end
    end
    piv_s = (CW'(d_piv[NW]) > CW'(32767)) ? 16'h7FFF : IN_W'(CW'(d_piv[NW]));
    case (ds_e.sel)
      SEL_X:   q_fin = {lane_s[2], lane_s[1], lane_s[0], piv_s};
      SEL_Y:   q_fin = {lane_s[2], lane_s[0], piv_s, lane_s[1]};
      SEL_Z:   q_fin = {lane_s[2], piv_s, lane_s[1], lane_s[0]};
      default: q_fin = {piv_s, lane_s[2], lane_s[1], lane_s[0]};
    endcase
    if (ds_e.bad) q_fin = '0;
    res = {ds_e.bad, q_fin};
  end

  // ---------------- output register and skid ----------------
  logic        out_v_r, skid_v_r;
  logic [64:0] out_d_r, skid_d_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= d_vld[NW];
      end
    end else if (d_vld[NW] && en) begin
      skid_v_r <= 1'b1;
    end
    if (!out_v_r || out_tready) begin
      out_d_r <= skid_v_r ? skid_d_r : res;
    end else if (d_vld[NW] && en) begin
      skid_d_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r[63:0];
  assign out_tuser  = out_d_r[64];

endmodule
